>>> rtl/kmer_histogram_counter_core_assert.svh
// assertion macros shared by the kmer histogram counter rtl
// expects i_clk and i_rst_n in the scope of the including module
`ifndef KMER_HISTOGRAM_COUNTER_CORE_ASSERT_SVH
`define KMER_HISTOGRAM_COUNTER_CORE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define KHC_ASSERT_SAME(label, ante, cons) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("khc same-cycle check failed");

// next-cycle implication, checked while out of reset
`define KHC_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("khc next-cycle check failed");

`endif

>>> rtl/khc_pkg.sv
// types, constants and the letter decoder of the kmer histogram counter
// no dependencies
package khc_pkg;

    localparam int INDEX_W     = 10;
    localparam int OUT_COUNT_W = 32;
    localparam int OP_W        = 2;
    localparam int CHAR_W      = 8;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 48;
    localparam int QUEUE_DEPTH = 3;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_FEED     = 2'd0,
        OP_READ     = 2'd1,
        OP_BOUNDARY = 2'd2
    } t_op;

    typedef logic [INDEX_W-1:0]     t_index;
    typedef logic [OUT_COUNT_W-1:0] t_count_out;

    // read_index in the low bits
    typedef struct packed {
        t_count_out count_value;
        t_index     read_index;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } t_letter;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CH_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CH_T_LO = 8'h74;

    // cr, lf and every other non-base byte decode as not ok
    function automatic t_letter decode_letter(input logic [CHAR_W-1:0] ch);
        t_letter res;
        res.ok   = 1'b1;
        res.code = CODE_A;
        case (ch)
            CH_A_UP, CH_A_LO: res.code = CODE_A;
            CH_C_UP, CH_C_LO: res.code = CODE_C;
            CH_G_UP, CH_G_LO: res.code = CODE_G;
            CH_T_UP, CH_T_LO: res.code = CODE_T;
            default:          res.ok   = 1'b0;
        endcase
        return res;
    endfunction

endpackage

>>> rtl/khc_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module khc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/khc_window.sv
// letter window: decodes bytes, shifts codes and tracks the valid run
// depends on khc_pkg
module khc_window #(
    parameter int WORD_LENGTH = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_feed,
    input  logic                     i_flush,
    input  logic [khc_pkg::CHAR_W-1:0] i_char,
    output logic                     o_hit,
    output logic [2*WORD_LENGTH-1:0] o_addr
);

    localparam int WB    = 2 * WORD_LENGTH;
    localparam int RUN_W = $clog2(WORD_LENGTH + 1);

    logic [WB-1:0]    r_window, n_window;
    logic [RUN_W-1:0] r_run, n_run;
    logic [WB-1:0]    shifted;
    logic [RUN_W-1:0] run_inc;
    khc_pkg::t_letter dec;

    assign dec     = khc_pkg::decode_letter(i_char);
    assign shifted = WB'({r_window, dec.code});
    assign run_inc = (r_run < RUN_W'(WORD_LENGTH)) ? r_run + RUN_W'(1) : r_run;

    always_comb begin
        n_window = r_window;
        n_run    = r_run;
        if (i_flush || (i_feed && !dec.ok)) begin
            n_window = '0;
            n_run    = '0;
        end else if (i_feed) begin
            n_window = shifted;
            n_run    = run_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_run    <= '0;
        end else begin
            r_window <= n_window;
            r_run    <= n_run;
        end
    end

    // the word completed by this letter, addressed in the same cycle
    assign o_hit  = i_feed && dec.ok && (run_inc == RUN_W'(WORD_LENGTH));
    assign o_addr = shifted;

endmodule

>>> rtl/khc_outq.sv
// three-word result queue between the histogram stage and the output port
// depends on khc_pkg
module khc_outq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  khc_pkg::t_result           i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output khc_pkg::t_result           o_data,
    output logic [khc_pkg::QCNT_W-1:0] o_count
);

    localparam int D = khc_pkg::QUEUE_DEPTH;

    khc_pkg::t_result            r_mem [D];
    logic [khc_pkg::QPTR_W-1:0]  r_head, r_tail;
    logic [khc_pkg::QCNT_W-1:0]  r_count, n_count;
    logic                        pop;

    function automatic logic [khc_pkg::QPTR_W-1:0] ptr_next(
        input logic [khc_pkg::QPTR_W-1:0] p);
        return (p == khc_pkg::QPTR_W'(D - 1)) ? '0 : p + khc_pkg::QPTR_W'(1);
    endfunction

    assign pop = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + khc_pkg::QCNT_W'(1);
        end else if (pop && !i_push) begin
            n_count = r_count - khc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_tail <= ptr_next(r_tail);
            end
            if (pop) begin
                r_head <= ptr_next(r_head);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head];
    assign o_count = r_count;

endmodule

>>> rtl/kmer_histogram_counter_core.sv
// top level of the kmer histogram counter: window, histogram ram with
// read-modify-write and forwarding, clearing pass, result queue
// depends on khc_pkg, khc_ram, khc_window, khc_outq and the assert header
//
//  port group | dir | tdata (low bit up)                   | tuser
//  s_axis     | in  | char_byte[7:0], word_index[17:8]     | operation[1:0]
//  m_axis     | out | read_index[9:0], count_value[41:10]  | -
//
// one word per cycle while s_axis_tready is high, feeds and reads mixed freely;
// a read result reaches m_axis through the ram read register at the accepting
// edge and then the result queue register
// after reset a clearing pass writes zero to every counter, all 4**WORD_LENGTH
// of them (1024 by default), and s_axis_tready stays low during it
// s_axis_tready also drops while three results wait or are in flight,
// which only happens when m_axis_tready holds low
`include "kmer_histogram_counter_core_assert.svh"

module kmer_histogram_counter_core #(
    parameter int WORD_LENGTH = 5,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input words
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [khc_pkg::S_TDATA_W-1:0] s_axis_tdata,  // char_byte, word_index
    input  logic [khc_pkg::OP_W-1:0]      s_axis_tuser,  // operation
    // result words
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [khc_pkg::M_TDATA_W-1:0] m_axis_tdata   // read_index, count_value
);

    localparam int WB    = 2 * WORD_LENGTH;
    localparam int DEPTH = 1 << WB;
    localparam int PEND_W = khc_pkg::QCNT_W + 1;

    // input side decode
    logic                           s_acc;
    logic                           is_read, is_feed, is_bound;
    logic [khc_pkg::CHAR_W-1:0]     in_char;
    khc_pkg::t_index                in_index;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign in_char  = s_axis_tdata[khc_pkg::CHAR_W-1:0];
    assign in_index = s_axis_tdata[khc_pkg::CHAR_W +: khc_pkg::INDEX_W];
    assign is_feed  = (s_axis_tuser == khc_pkg::OP_FEED);
    assign is_read  = (s_axis_tuser == khc_pkg::OP_READ);
    assign is_bound = (s_axis_tuser == khc_pkg::OP_BOUNDARY);

    // letter window
    logic          win_hit;
    logic [WB-1:0] win_addr;

    khc_window #(
        .WORD_LENGTH (WORD_LENGTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_feed  (s_acc && is_feed),
        .i_flush (s_acc && is_bound),
        .i_char  (in_char),
        .o_hit   (win_hit),
        .o_addr  (win_addr)
    );

    // clearing pass after reset
    logic          r_clr_busy;
    logic [WB-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + WB'(1);
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // stage 1: ram data arrives, counter is updated or returned
    logic          r_s1_valid;
    logic          r_s1_read;
    logic [WB-1:0] r_s1_addr;
    logic [WB-1:0] rd_addr;

    // a read uses the masked word code, a feed the freshly shifted window
    assign rd_addr = is_read ? WB'(in_index) : win_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= s_acc && (is_read || win_hit);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_read <= is_read;
        r_s1_addr <= rd_addr;
    end

    // histogram memory
    logic                   ram_we;
    logic [WB-1:0]          ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [COUNT_WIDTH-1:0] ram_q;

    khc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // forwarding: the write of the previous cycle may not be in ram_q yet
    logic                   r_fwd_valid;
    logic [WB-1:0]          r_fwd_addr;
    logic [COUNT_WIDTH-1:0] r_fwd_data;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] inc_count;
    logic                   s1_wr;

    assign cur_count = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : ram_q;
    // saturate at all ones
    assign inc_count = (cur_count == '1) ? cur_count : cur_count + COUNT_WIDTH'(1);
    assign s1_wr     = r_s1_valid && !r_s1_read;

    assign ram_we    = r_clr_busy || s1_wr;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign ram_wdata = r_clr_busy ? '0 : inc_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= s1_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= inc_count;
    end

    // result queue
    khc_pkg::t_result            s1_result, q_data;
    logic [khc_pkg::QCNT_W-1:0]  q_count;
    logic                        s1_read_pending;
    logic [PEND_W-1:0]           pending;

    assign s1_read_pending       = r_s1_valid && r_s1_read;
    assign s1_result.read_index  = khc_pkg::t_index'(r_s1_addr);
    assign s1_result.count_value = khc_pkg::t_count_out'(cur_count);

    khc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s1_read_pending),
        .i_data  (s1_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign m_axis_tdata = khc_pkg::M_TDATA_W'(q_data);

    // room for one more result counting the one still in stage 1
    assign pending       = PEND_W'(q_count) + PEND_W'(s1_read_pending);
    assign s_axis_tready = !r_clr_busy && (pending < PEND_W'(khc_pkg::QUEUE_DEPTH));

    // checks
    `KHC_ASSERT_SAME(a_queue_room, 1'b1, pending <= PEND_W'(khc_pkg::QUEUE_DEPTH))
    `KHC_ASSERT_SAME(a_clear_quiet, r_clr_busy, !r_s1_valid && !s_axis_tready)
    `KHC_ASSERT_NEXT(a_read_issue, s_acc && is_read, r_s1_valid && r_s1_read)
    `KHC_ASSERT_NEXT(a_fwd_track, s1_wr, r_fwd_valid && (r_fwd_addr == $past(r_s1_addr)))
    `KHC_ASSERT_SAME(a_sat_hold, s1_wr && (cur_count == '1), ram_wdata == '1)

endmodule

>>> bench/testbench.sv
// self-checking bench for kmer_histogram_counter_core: letter streams, reads and breaks
// depends on khc_pkg and the core rtl; keeps its own histogram to predict every read
`timescale 1ns / 100ps

module testbench;
    import khc_pkg::*;

    localparam int KMER_LEN = 5;
    localparam int WIN_W    = 2 * KMER_LEN;

    // operation code the core ignores
    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // char_byte, word_index
    logic [OP_W-1:0]      s_axis_tuser;   // operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // read_index, count_value

    // shadow histogram and letter window
    logic [WIN_W-1:0] window_bits;
    logic [2:0]       letters_held;
    logic [31:0]      word_tally [0:(1 << WIN_W) - 1];
    t_result          pending_counts [$];

    // upper case row first, then lower case
    logic [CHAR_W-1:0] base_chars [0:1][0:3] = '{
        '{CH_A_UP, CH_C_UP, CH_G_UP, CH_T_UP},
        '{CH_A_LO, CH_C_LO, CH_G_LO, CH_T_LO}
    };

    int mismatch_count    = 0;
    bit src_gaps_on       = 1'b0;
    bit sink_gaps_on      = 1'b0;
    int sink_hold_cycles  = 0;
    bit sink_holding      = 1'b0;

    kmer_histogram_counter_core #(
        .WORD_LENGTH (KMER_LEN),
        .COUNT_WIDTH (32)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #20_000_000;
        $display("testbench failed");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("mismatch on %s: got %0d, expected %0d", field, got_v, want_v);
        mismatch_count++;
    endtask

    // shadow of the core for one accepted word; a read queues its answer
    task automatic predict_histogram(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                     input logic [INDEX_W-1:0] idx);
        logic       is_base;
        logic [1:0] code;
        t_result    answer;
        is_base = 1'b1;
        code    = CODE_A;
        case (op)
            OP_FEED: begin
                case (ch)
                    CH_A_UP, CH_A_LO: code = CODE_A;
                    CH_C_UP, CH_C_LO: code = CODE_C;
                    CH_G_UP, CH_G_LO: code = CODE_G;
                    CH_T_UP, CH_T_LO: code = CODE_T;
                    default:          is_base = 1'b0;
                endcase
                if (!is_base) begin
                    // cr, lf or any other byte breaks the run
                    window_bits  = '0;
                    letters_held = '0;
                end else begin
                    window_bits = {window_bits[WIN_W-3:0], code};
                    if (letters_held < KMER_LEN)
                        letters_held = letters_held + 3'd1;
                    // counters stick at all ones
                    if (letters_held == KMER_LEN && word_tally[window_bits] != '1)
                        word_tally[window_bits] = word_tally[window_bits] + 32'd1;
                end
            end
            OP_READ: begin
                answer.read_index  = idx;
                answer.count_value = word_tally[idx];
                pending_counts.push_back(answer);
            end
            OP_BOUNDARY: begin
                window_bits  = '0;
                letters_held = '0;
            end
            default: ;
        endcase
    endtask

    // offers one word, optionally after a random gap, and returns once it is taken
    task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [INDEX_W-1:0] idx);
        int gap;
        if (src_gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= S_TDATA_W'($urandom);
            s_axis_tuser  <= OP_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - INDEX_W - CHAR_W){1'b0}}, idx, ch};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_histogram(op, ch, idx);
    endtask

    // sender goes quiet until every queued read has come back
    task automatic wait_results_drained;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_counts.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CHAR_W-1:0] pick_letter(input int code);
        return base_chars[1'($urandom_range(0, 1))][2'(code)];
    endfunction

    function automatic logic [CHAR_W-1:0] rand_char();
        return CHAR_W'($urandom);
    endfunction

    function automatic logic [INDEX_W-1:0] rand_index();
        return INDEX_W'($urandom);
    endfunction

    task automatic feed_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_word(OP_FEED, text[i], rand_index());
    endtask

    // edges of the index range, case mixing, run breakers, ignored code, read mid-run
    task automatic test_directed;
        send_word(OP_READ, 8'hFF, '0);
        send_word(OP_READ, 8'h00, '1);
        feed_text("ACGTAc");
        send_word(OP_READ, rand_char(), window_bits);
        feed_text("\rT\n");
        send_word(OP_FEED, 8'hFF, '0);
        send_word(OP_FEED, 8'h00, '1);
        send_word(OP_UNUSED, 8'hFF, '1);
        // boundary in the middle of a run leaves nothing counted
        feed_text("TTT");
        send_word(OP_BOUNDARY, rand_char(), rand_index());
        feed_text("TTtt");
        send_word(OP_READ, rand_char(), '1);
        feed_text("T");
        send_word(OP_READ, rand_char(), '1);
    endtask

    // mostly letter runs of several shapes, with reads, breakers and boundaries mixed in
    task automatic test_random_traffic(input int n_words);
        int             sent;
        int             pick;
        int             len;
        int             style;
        int             code_a;
        int             code_b;
        int             c;
        logic [INDEX_W-1:0] idx;
        sent = 0;
        while (sent < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len    = $urandom_range(1, 24);
                style  = $urandom_range(0, 3);
                code_a = $urandom_range(0, 3);
                code_b = $urandom_range(0, 3);
                for (int i = 0; i < len; i++) begin
                    case (style)
                        0:       c = $urandom_range(0, 3);
                        1:       c = code_a;   // one letter repeated, same word back to back
                        2:       c = (i % 2) ? code_b : code_a;
                        default: c = $urandom_range(0, 1) ? code_b : code_a;
                    endcase
                    send_word(OP_FEED, pick_letter(c), rand_index());
                end
                sent += len;
            end else if (pick < 78) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 3))
                        0, 1:    idx = window_bits;   // word just counted
                        2:       idx = rand_index();
                        default: idx = $urandom_range(0, 1) ? '1 : '0;
                    endcase
                    send_word(OP_READ, rand_char(), idx);
                end
                sent += len;
            end else if (pick < 88) begin
                case ($urandom_range(0, 2))
                    0:       send_word(OP_FEED, CH_CR, rand_index());
                    1:       send_word(OP_FEED, CH_LF, rand_index());
                    default: send_word(OP_FEED, rand_char(), rand_index());
                endcase
                sent++;
            end else if (pick < 95) begin
                send_word(OP_BOUNDARY, rand_char(), rand_index());
                sent++;
            end else begin
                send_word(OP_UNUSED, rand_char(), rand_index());
            end
        end
    endtask

    // receiver stops for a long stretch while reads keep coming, so the result
    // queue fills and the input side has to stall
    task automatic test_output_backpressure;
        wait_results_drained();
        src_gaps_on      = 1'b0;
        sink_hold_cycles = 150;
        wait (sink_holding);
        for (int i = 0; i < 24; i++) begin
            if (i % 3 == 2)
                send_word(OP_FEED, pick_letter($urandom_range(0, 3)), rand_index());
            else
                send_word(OP_READ, rand_char(), rand_index());
        end
        wait_results_drained();
        src_gaps_on = 1'b1;
    endtask

    // receiver: long hold on request, random short stalls otherwise
    initial begin
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (sink_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                sink_holding = 1'b1;
                repeat (sink_hold_cycles) @(posedge i_clk);
                sink_hold_cycles = 0;
                sink_holding     = 1'b0;
            end else if (sink_gaps_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // every result word is matched against the oldest queued read
    always @(posedge i_clk) begin : result_check
        t_result got_word;
        t_result want_word;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_word = m_axis_tdata[$bits(t_result)-1:0];
            if (pending_counts.size() == 0) begin
                report_mismatch("unexpected result, read_index",
                                32'(got_word.read_index), 32'd0);
            end else begin
                want_word = pending_counts.pop_front();
                if (got_word.read_index !== want_word.read_index)
                    report_mismatch("read_index", 32'(got_word.read_index),
                                    32'(want_word.read_index));
                if (got_word.count_value !== want_word.count_value)
                    report_mismatch("count_value", got_word.count_value,
                                    want_word.count_value);
            end
        end
    end

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_rst_n       <= 1'b0;
        window_bits  = '0;
        letters_held = '0;
        foreach (word_tally[i]) word_tally[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the clearing pass after reset shows up as a long input stall
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        test_directed();
        test_random_traffic(700);
        test_output_backpressure();

        // closing stretch at full rate on both sides
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        test_random_traffic(600);

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
